[hdl/cse_pkg.sv]
// Shared types and constants for the C string escape encoder.
// Holds the request payload structs and the job record passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package cse_pkg;

	localparam int unsigned CharW      = 8;
	localparam int unsigned CountW     = 16;
	localparam int unsigned MaxChars   = 4;
	localparam int unsigned NumCharW   = $clog2(MaxChars + 1);
	localparam int unsigned CharIdxW   = $clog2(MaxChars);
	localparam int unsigned IdxW       = $clog2(MaxChars + 2);
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned PtrW       = $clog2(QueueDepth);
	localparam int unsigned FillW      = $clog2(QueueDepth + 1);

	localparam logic [CountW-1:0] CapacityReset = 16'd256;

	localparam logic [CharW-1:0] ChBackslash = 8'h5c;
	localparam logic [CharW-1:0] ChQuote     = 8'h22;
	localparam logic [CharW-1:0] ChLowerX    = 8'h78;
	localparam logic [CharW-1:0] ChZero      = 8'h30;
	localparam logic [CharW-1:0] ChNul       = 8'h00;
	localparam logic [CharW-1:0] HighNibble  = 8'hf0;
	localparam logic [CharW-1:0] LowNibble   = 8'h0f;

	typedef struct packed {
		logic [CharW-1:0] data_byte;
		logic             end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [CharW-1:0]  out_char;
		logic              run_last;
		logic              is_terminator;
		logic [CountW-1:0] total_length;
		logic              truncated;
	} out_item_t;

	typedef struct packed {
		logic [MaxChars-1:0][CharW-1:0] chars;
		logic [NumCharW-1:0]            num_chars;
		logic                           term;
		logic [CountW-1:0]              term_len;
		logic                           trunc;
	} job_t;

endpackage

[hdl/cse_front.sv]
// Front end of the escape encoder: accepts requests, classifies each byte and
// keeps the string state. Depends on cse_pkg for the payload and job types.
`timescale 1ns / 1ps

module cse_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cse_pkg::in_item_t             in_data,
	input  logic                          cfg_we,
	input  logic [cse_pkg::CountW-1:0]    cfg_data,
	input  logic                          queue_full,
	output logic                          push,
	output cse_pkg::job_t                 push_job
);

	logic [cse_pkg::CountW-1:0] capacity_q;
	logic [cse_pkg::CountW-1:0] space_left_q;
	logic [cse_pkg::CountW-1:0] chars_written_q;
	logic                       halted_q;

	logic                                         accept;
	logic [cse_pkg::CharW-1:0]                    c;
	logic [cse_pkg::MaxChars-1:0][cse_pkg::CharW-1:0] chars;
	logic [cse_pkg::NumCharW-1:0]                 len;
	logic                                         no_fit;
	logic [cse_pkg::CountW-1:0]                   len_ext;

	function automatic logic [cse_pkg::CharW-1:0] hex_digit(input logic [3:0] n);
		if (n < 4'd10) begin
			return cse_pkg::ChZero + {4'd0, n};
		end
		return 8'h61 + {4'd0, n - 4'd10};
	endfunction

	function automatic logic [cse_pkg::CharW-1:0] ctrl_letter(input logic [cse_pkg::CharW-1:0] b);
		logic [cse_pkg::CharW-1:0] r;
		case (b)
			8'd7:    r = 8'h61;
			8'd8:    r = 8'h62;
			8'd9:    r = 8'h74;
			8'd10:   r = 8'h6e;
			8'd11:   r = 8'h76;
			8'd12:   r = 8'h66;
			default: r = 8'h72;
		endcase
		return r;
	endfunction

	assign c        = in_data.data_byte;
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		chars = '0;
		if (c == 8'd0) begin
			chars[0] = cse_pkg::ChBackslash;
			chars[1] = cse_pkg::ChZero;
			len      = cse_pkg::NumCharW'(2);
		end else if (c inside {[8'd7:8'd13]}) begin
			chars[0] = cse_pkg::ChBackslash;
			chars[1] = ctrl_letter(c);
			len      = cse_pkg::NumCharW'(2);
		end else if (c == cse_pkg::ChQuote || c == cse_pkg::ChBackslash) begin
			chars[0] = cse_pkg::ChBackslash;
			chars[1] = c;
			len      = cse_pkg::NumCharW'(2);
		end else if (c inside {[8'd32:8'd126]}) begin
			chars[0] = c;
			len      = cse_pkg::NumCharW'(1);
		end else begin
			chars[0] = cse_pkg::ChBackslash;
			chars[1] = cse_pkg::ChLowerX;
			chars[2] = hex_digit(4'((c & cse_pkg::HighNibble) >> 4));
			chars[3] = hex_digit(4'(c & cse_pkg::LowNibble));
			len      = cse_pkg::NumCharW'(4);
		end
	end

	assign len_ext = {{(cse_pkg::CountW-cse_pkg::NumCharW){1'b0}}, len};
	assign no_fit  = space_left_q <= len_ext;

	always_comb begin
		push_job = '0;
		push     = accept && !halted_q;
		if (no_fit) begin
			push_job.term     = 1'b1;
			push_job.term_len = chars_written_q;
			push_job.trunc    = 1'b1;
		end else begin
			push_job.chars     = chars;
			push_job.num_chars = len;
			push_job.term      = in_data.end_of_data;
			push_job.term_len  = chars_written_q + len_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q      <= cse_pkg::CapacityReset;
			space_left_q    <= cse_pkg::CapacityReset;
			chars_written_q <= '0;
			halted_q        <= 1'b0;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
			if (!halted_q && chars_written_q == '0) begin
				space_left_q <= cfg_data;
			end
		end else if (accept) begin
			if (in_data.end_of_data) begin
				space_left_q    <= capacity_q;
				chars_written_q <= '0;
				halted_q        <= 1'b0;
			end else if (!halted_q) begin
				if (no_fit) begin
					halted_q <= 1'b1;
				end else begin
					space_left_q    <= space_left_q - len_ext;
					chars_written_q <= chars_written_q + len_ext;
				end
			end
		end
	end

endmodule

[hdl/cse_queue.sv]
// Short job queue between the front and back ends of the escape encoder.
// Depends on cse_pkg for the job type and the queue depth.
`timescale 1ns / 1ps

module cse_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cse_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output cse_pkg::job_t head
);

	cse_pkg::job_t                mem [cse_pkg::QueueDepth];
	logic [cse_pkg::PtrW-1:0]     wr_ptr_q;
	logic [cse_pkg::PtrW-1:0]     rd_ptr_q;
	logic [cse_pkg::FillW-1:0]    fill_q;

	assign full  = fill_q == cse_pkg::FillW'(cse_pkg::QueueDepth);
	assign empty = fill_q == '0;
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == cse_pkg::PtrW'(cse_pkg::QueueDepth - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == cse_pkg::PtrW'(cse_pkg::QueueDepth - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[hdl/cse_back.sv]
// Back end of the escape encoder: holds one job and emits its characters and
// terminator one per cycle while out_ready is high; types come from cse_pkg.
`timescale 1ns / 1ps

module cse_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               queue_empty,
	input  cse_pkg::job_t      head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output cse_pkg::out_item_t out_data
);

	cse_pkg::job_t            job_q;
	logic                     valid_q;
	logic [cse_pkg::IdxW-1:0] idx_q;
	logic [cse_pkg::IdxW-1:0] count;
	logic                     last;
	logic                     in_chars;
	logic                     load;

	assign count    = cse_pkg::IdxW'(job_q.num_chars) + cse_pkg::IdxW'(job_q.term);
	assign last     = idx_q == count - 1'b1;
	assign in_chars = idx_q < cse_pkg::IdxW'(job_q.num_chars);
	assign load     = !valid_q || (out_ready && last);
	assign pop      = load && !queue_empty;

	assign out_valid = valid_q;

	always_comb begin
		out_data          = '0;
		out_data.run_last = last;
		if (in_chars) begin
			out_data.out_char = job_q.chars[idx_q[cse_pkg::CharIdxW-1:0]];
		end else begin
			out_data.out_char      = cse_pkg::ChNul;
			out_data.is_terminator = 1'b1;
			out_data.total_length  = job_q.term_len;
			out_data.truncated     = job_q.trunc;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !queue_empty;
			idx_q   <= '0;
		end else if (out_ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

[hdl/c_string_escape_encoder.sv]
// Top level of the C string escape encoder.
// Instantiates cse_front, cse_queue and cse_back; types come from cse_pkg.
// Each request carries one raw byte and yields one to five characters of C literal
// text, one per cycle while the receiver is ready: one for a plain printable byte,
// two for a short escape, four for a hex escape, plus one when the string's
// terminator follows. The back end emits a single character at a time; the front
// end takes a request every cycle while the two-entry job queue has room, and
// requests dropped after a truncation produce nothing.
`timescale 1ns / 1ps

module c_string_escape_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  cse_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cse_pkg::out_item_t         out_data,
	input  logic                       cfg_we,
	input  logic [cse_pkg::CountW-1:0] cfg_data
);

	logic          push;
	logic          pop;
	logic          queue_full;
	logic          queue_empty;
	cse_pkg::job_t push_job;
	cse_pkg::job_t head;

	cse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	cse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.head     (head)
	);

	cse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

[tb/sv/cse_checker.sv]
// Checker for the C string escape encoder: predicts the characters of every request
// and compares each accepted result with the oldest prediction.
// Depends on cse_pkg for the payload structs and the character constants.
`timescale 1ns / 1ps

module cse_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  cse_pkg::in_item_t          in_data,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  cse_pkg::out_item_t         out_data,
	input  logic                       cfg_we,
	input  logic [cse_pkg::CountW-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending
);

	localparam logic [cse_pkg::CharW-1:0] ChBell   = 8'h07;
	localparam logic [cse_pkg::CharW-1:0] ChReturn = 8'h0d;
	localparam logic [cse_pkg::CharW-1:0] ChSpace  = 8'h20;
	localparam logic [cse_pkg::CharW-1:0] ChTilde  = 8'h7e;
	localparam logic [7*cse_pkg::CharW-1:0]  ShortLetters = "abtnvfr";
	localparam logic [16*cse_pkg::CharW-1:0] HexDigits    = "0123456789abcdef";

	logic [cse_pkg::CountW-1:0] capacity;
	logic [cse_pkg::CountW-1:0] space_left;
	logic [cse_pkg::CountW-1:0] chars_written;
	logic                       halted;
	cse_pkg::out_item_t         expected_chars[$];

	function automatic logic [cse_pkg::CharW-1:0] hex_digit(
			input logic [cse_pkg::CharW-1:0] nibble);
		return HexDigits[(15 - nibble) * cse_pkg::CharW +: cse_pkg::CharW];
	endfunction

	function automatic int unsigned escape_text(input logic [cse_pkg::CharW-1:0] c,
			output logic [cse_pkg::MaxChars-1:0][cse_pkg::CharW-1:0] txt);
		txt = '0;
		txt[0] = cse_pkg::ChBackslash;
		if (c == cse_pkg::ChNul) begin
			txt[1] = cse_pkg::ChZero;
			return 2;
		end else if (c >= ChBell && c <= ChReturn) begin
			txt[1] = ShortLetters[(ChReturn - c) * cse_pkg::CharW +: cse_pkg::CharW];
			return 2;
		end else if (c == cse_pkg::ChQuote || c == cse_pkg::ChBackslash) begin
			txt[1] = c;
			return 2;
		end else if (c >= ChSpace && c <= ChTilde) begin
			txt[0] = c;
			return 1;
		end
		txt[1] = cse_pkg::ChLowerX;
		txt[2] = hex_digit((c & cse_pkg::HighNibble) >> 4);
		txt[3] = hex_digit(c & cse_pkg::LowNibble);
		return 4;
	endfunction

	task automatic restart_string();
		space_left    = capacity;
		chars_written = '0;
		halted        = 1'b0;
	endtask

	task automatic push_char(input logic [cse_pkg::CharW-1:0] ch, input logic last,
			input logic term, input logic [cse_pkg::CountW-1:0] len, input logic trunc);
		cse_pkg::out_item_t res;
		res.out_char      = ch;
		res.run_last      = last;
		res.is_terminator = term;
		res.total_length  = len;
		res.truncated     = trunc;
		expected_chars.push_back(res);
	endtask

	task automatic predict_request(input cse_pkg::in_item_t req);
		logic [cse_pkg::MaxChars-1:0][cse_pkg::CharW-1:0] txt;
		int unsigned n;
		if (halted) begin
			if (req.end_of_data)
				restart_string();
			return;
		end
		n = escape_text(req.data_byte, txt);
		if (space_left <= n) begin
			push_char(cse_pkg::ChNul, 1'b1, 1'b1, chars_written, 1'b1);
			if (req.end_of_data)
				restart_string();
			else
				halted = 1'b1;
			return;
		end
		for (int unsigned i = 0; i < n; i++)
			push_char(txt[i], !req.end_of_data && (i + 1 == n), 1'b0, '0, 1'b0);
		space_left    = space_left - cse_pkg::CountW'(n);
		chars_written = chars_written + cse_pkg::CountW'(n);
		if (req.end_of_data) begin
			push_char(cse_pkg::ChNul, 1'b1, 1'b1, chars_written, 1'b0);
			restart_string();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch in %s: got 'h%0h, expected 'h%0h", $realtime, what, got,
			want);
		fail_count++;
	endtask

	task automatic check_result(input cse_pkg::out_item_t got);
		cse_pkg::out_item_t want;
		if (expected_chars.size() == 0) begin
			report_mismatch("result with nothing expected", 32'(got), '0);
			return;
		end
		want = expected_chars.pop_front();
		if (got.out_char !== want.out_char)
			report_mismatch("out_char", 32'(got.out_char), 32'(want.out_char));
		if (got.run_last !== want.run_last)
			report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
		if (got.is_terminator !== want.is_terminator)
			report_mismatch("is_terminator", 32'(got.is_terminator),
				32'(want.is_terminator));
		if (got.total_length !== want.total_length)
			report_mismatch("total_length", 32'(got.total_length),
				32'(want.total_length));
		if (got.truncated !== want.truncated)
			report_mismatch("truncated", 32'(got.truncated), 32'(want.truncated));
	endtask

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity = cse_pkg::CapacityReset;
			restart_string();
			expected_chars.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				capacity = cfg_data;
				if (!halted && chars_written == 0)
					space_left = capacity;
			end
			if (in_valid && in_ready)
				predict_request(in_data);
			if (out_valid && out_ready)
				check_result(out_data);
			pending = expected_chars.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
// Top of the escape encoder testbench: clock, reset, request stimulus, capacity
// writes and output back-pressure, with the verdict taken from cse_checker.
// Depends on cse_pkg, cse_checker and the c_string_escape_encoder RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int SettleCycles  = 16;
	localparam int SegmentItems  = 36;
	localparam int NumSegments   = 12;
	localparam int LongHoldCycles = 300;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	cse_pkg::in_item_t          in_data = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	cse_pkg::out_item_t         out_data;
	logic                       cfg_we = 1'b0;
	logic [cse_pkg::CountW-1:0] cfg_data = '0;
	int                         fail_count;
	int                         pending;

	int unsigned snd_idle = 11;
	int unsigned rcv_idle = 77;
	bit          hold_go = 1'b0;
	logic        long_hold = 1'b0;

	c_string_escape_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	cse_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= !long_hold && ($urandom_range(99) >= rcv_idle);
	end

	// The receiver refuses everything for a long stretch so that the queue fills.
	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (LongHoldCycles) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_request(input logic [cse_pkg::CharW-1:0] b, input logic eod);
		while ($urandom_range(99) < snd_idle) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= cse_pkg::in_item_t'{data_byte: b, end_of_data: eod};
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [cse_pkg::CountW-1:0] value);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	function automatic logic [cse_pkg::CharW-1:0] random_byte();
		case ($urandom_range(9))
			0: return cse_pkg::ChNul;
			1: return cse_pkg::CharW'($urandom_range(13, 7));
			2: return $urandom_range(1) ? cse_pkg::ChQuote : cse_pkg::ChBackslash;
			3, 4, 5: return cse_pkg::CharW'($urandom_range(126, 32));
			6, 7, 8: begin
				case ($urandom_range(2))
					0: return cse_pkg::CharW'($urandom_range(6, 1));
					1: return cse_pkg::CharW'($urandom_range(31, 14));
					default: return cse_pkg::CharW'($urandom_range(255, 127));
				endcase
			end
			default: return cse_pkg::CharW'($urandom_range(255));
		endcase
	endfunction

	initial begin
		int unsigned str_left;
		logic [cse_pkg::CountW-1:0] cap;
		str_left = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Every escape class at the reset capacity.
		send_request(cse_pkg::ChNul, 1'b0);
		for (int c = 7; c <= 13; c++)
			send_request(cse_pkg::CharW'(c), 1'b0);
		send_request(cse_pkg::ChQuote, 1'b0);
		send_request(cse_pkg::ChBackslash, 1'b0);
		send_request(8'h20, 1'b0);
		send_request(8'h7e, 1'b0);
		send_request(8'h80, 1'b0);
		send_request(8'hff, 1'b1);

		// Truncation mid-string, then dropped requests up to the end marker.
		write_capacity(16'd5);
		send_request(8'hff, 1'b0);
		send_request(8'h61, 1'b0);
		send_request(8'h62, 1'b0);
		send_request(8'h63, 1'b1);
		send_request(8'h64, 1'b1);
		// Truncation on the request that also ends the string.
		send_request(8'h1f, 1'b0);
		send_request(8'h80, 1'b1);
		// A capacity write in the middle of a string waits for the next reload.
		send_request(8'h61, 1'b0);
		write_capacity(16'd2);
		send_request(8'h62, 1'b1);
		// Capacities too small for any character.
		write_capacity(16'd1);
		send_request(8'h61, 1'b1);
		write_capacity(16'd0);
		send_request(cse_pkg::ChNul, 1'b1);

		for (int seg = 0; seg < NumSegments; seg++) begin
			case (seg)
				0: cap = 16'd2;
				3: cap = 16'd3;
				5: cap = cse_pkg::CountW'($urandom_range(65534, 41));
				7: cap = 16'd1;
				8: cap = 16'hffff;
				10: cap = 16'd0;
				default: cap = cse_pkg::CountW'($urandom_range(40, 4));
			endcase
			write_capacity(cap);
			if (seg % 4 == 0) begin
				@(posedge clk);
				case (seg / 4)
					0: begin
						snd_idle = 11;
						rcv_idle = 77;
					end
					1: begin
						snd_idle = 77;
						rcv_idle = 11;
					end
					default: begin
						snd_idle = 0;
						rcv_idle = 0;
						hold_go  = 1'b1;
					end
				endcase
			end
			for (int n = 0; n < SegmentItems; n++) begin
				if (str_left == 0 && $urandom_range(11) == 0) begin
					send_request(random_byte(), 1'b1);
				end else begin
					if (str_left == 0)
						str_left = ($urandom_range(9) == 0) ? $urandom_range(40, 16)
							: $urandom_range(8, 1);
					str_left--;
					send_request(random_byte(), str_left == 0);
				end
			end
		end

		drain();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
hdl/cse_pkg.sv
hdl/cse_front.sv
hdl/cse_queue.sv
hdl/cse_back.sv
hdl/c_string_escape_encoder.sv
tb/sv/cse_checker.sv
tb/sv/testbench.sv
